@@ rtl/core/bfvsp_pkg.sv @@
// Shared widths, codes and reset values for the BFV scaled plaintext add/sub block.
package bfvsp_pkg;

  localparam int unsigned WordW = 61;
  localparam int unsigned NumW  = 123;
  localparam int unsigned QuoW  = 64;
  localparam int unsigned ProdW = 122;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned InDataW = 128;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned NumModuliDefault = 3;

  localparam logic [WordW-1:0] PlainModReset = 61'd65537;
  localparam logic [WordW-1:0] ModulusReset  = 61'd2;

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_SUB        = 2'd1,
    OP_ADD_SCALED = 2'd2,
    OP_SUB_SCALED = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PLAIN_MOD       = 4'd0,
    REG_COEFF_MOD_PLAIN = 4'd1,
    REG_MODULUS_BASE    = 4'd2,
    REG_SCALE_BASE      = 4'd5
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] ll;
    logic [60:0] lh;
    logic [60:0] hl;
    logic [57:0] hh;
  } pp_t;

endpackage

@@ rtl/core/bfv_scaled_plain_add_sub.sv @@
// Top level: pipelined BFV plaintext add/sub on one RNS residue per word.
//
// Input stream (s_axis_*): one word per residue carrying opcode, plaintext
// coefficient m, residue index j and ciphertext residue c. Output stream
// (m_axis_*): the updated residue mod q_j; c passes through if j >= NUM_MODULI.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i at the
// clock edge; write only while no word is in flight.
// Throughput: one word per cycle while s_axis_tready is high. The two
// restoring dividers have 123 one-bit stages each (rounding fix divided by t,
// then the scaled term reduced mod q_j); the pipeline also has multiply,
// sum, merge and output stages.
// Reset clears all valid bits and loads the register reset values.
// A stalled receiver holds the output word; one more word lands in a skid
// register, after which s_axis_tready drops and the whole pipeline holds.
module bfv_scaled_plain_add_sub import bfvsp_pkg::*; #(
  parameter int unsigned NUM_MODULI = NumModuliDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WordW-1:0]    cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // opcode[1:0], plain_coeff[62:2], residue_index[64:63], cipher_residue[125:65]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // updated_residue[60:0]
  output logic [OutDataW-1:0] m_axis_tdata
);

  typedef struct packed {
    opcode_e          op;
    logic [1:0]       j;
    logic [WordW-1:0] m;
    logic [WordW-1:0] c;
    pp_t              pa;
    pp_t              pb;
  } p1_t;

  typedef struct packed {
    opcode_e          op;
    logic [1:0]       j;
    logic [WordW-1:0] m;
    logic [WordW-1:0] c;
    logic [NumW-1:0]  num;
    logic [ProdW-1:0] prod;
  } p2_t;

  typedef struct packed {
    opcode_e          op;
    logic [1:0]       j;
    logic [WordW-1:0] m;
    logic [WordW-1:0] c;
    logic [WordW-1:0] crem;
    logic [NumW-1:0]  num;
    logic [WordW-1:0] rem;
    logic [QuoW-1:0]  quo;
    logic [ProdW-1:0] prod;
  } d1_t;

  typedef struct packed {
    opcode_e          op;
    logic [1:0]       j;
    logic [WordW-1:0] c;
    logic [WordW-1:0] crem;
    logic [NumW-1:0]  num;
    logic [WordW-1:0] rem;
  } d2_t;

  logic [WordW-1:0] plain_mod_q, coeff_mp_q;
  logic [WordW-1:0] moduli_q [NUM_MODULI];
  logic [WordW-1:0] scales_q [NUM_MODULI];

  function automatic logic [WordW-1:0] sel_mod(input logic [1:0] j);
    logic [WordW-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_MODULI; i++) begin
      if (j == 2'(i)) r = moduli_q[i];
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] sel_scale(input logic [1:0] j);
    logic [WordW-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_MODULI; i++) begin
      if (j == 2'(i)) r = scales_q[i];
    end
    return r;
  endfunction

  function automatic pp_t mul_pp(input logic [WordW-1:0] a, input logic [WordW-1:0] b);
    pp_t p;
    p.ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    p.lh = {29'd0, a[31:0]} * {32'd0, b[60:32]};
    p.hl = {32'd0, a[60:32]} * {29'd0, b[31:0]};
    p.hh = {29'd0, a[60:32]} * {29'd0, b[60:32]};
    return p;
  endfunction

  function automatic logic [ProdW-1:0] sum_pp(input pp_t p);
    return ProdW'(p.ll) + (ProdW'(p.lh) << 32) + (ProdW'(p.hl) << 32) + (ProdW'(p.hh) << 64);
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_mod_q <= PlainModReset;
      coeff_mp_q  <= '0;
      for (int i = 0; i < NUM_MODULI; i++) begin
        moduli_q[i] <= ModulusReset;
        scales_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_PLAIN_MOD) plain_mod_q <= cfg_data_i;
      if (cfg_idx_i == REG_COEFF_MOD_PLAIN) coeff_mp_q <= cfg_data_i;
      for (int i = 0; i < NUM_MODULI; i++) begin
        if (cfg_idx_i == CfgIdxW'(REG_MODULUS_BASE + i)) moduli_q[i] <= cfg_data_i;
        if (cfg_idx_i == CfgIdxW'(REG_SCALE_BASE + i)) scales_q[i] <= cfg_data_i;
      end
    end
  end

  logic en;
  logic skid_vld_q, out_vld_q;
  logic [WordW-1:0] skid_q, out_q;

  assign en = !skid_vld_q;
  assign s_axis_tready = en;

  // stage 1: partial products
  logic p1_vld_q;
  p1_t  p1_q, p1_d;
  always_comb begin
    p1_d.op = opcode_e'(s_axis_tdata[1:0]);
    p1_d.m  = s_axis_tdata[62:2];
    p1_d.j  = s_axis_tdata[64:63];
    p1_d.c  = s_axis_tdata[125:65];
    p1_d.pa = mul_pp(coeff_mp_q, s_axis_tdata[62:2]);
    p1_d.pb = mul_pp(s_axis_tdata[62:2], sel_scale(s_axis_tdata[64:63]));
  end

  // stage 2: sums
  logic p2_vld_q;
  p2_t  p2_q, p2_d;
  logic [WordW:0] thr_sum;
  always_comb begin
    thr_sum    = {1'b0, plain_mod_q} + 62'd1;
    p2_d.op    = p1_q.op;
    p2_d.j     = p1_q.j;
    p2_d.m     = p1_q.m;
    p2_d.c     = p1_q.c;
    p2_d.num   = NumW'(sum_pp(p1_q.pa)) + NumW'(thr_sum[WordW:1]);
    p2_d.prod  = sum_pp(p1_q.pb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= s_axis_tvalid;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  // divider 1: fix = num / t, with c mod q_j alongside
  logic d1_vld_q [NumW];
  d1_t  d1_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_div1
    d1_t              src, nxt;
    logic             src_vld;
    logic [WordW:0]   r2;
    logic [WordW-1:0] crem_d;
    if (k == 0) begin : g_first
      always_comb begin
        src_vld   = p2_vld_q;
        src.op    = p2_q.op;
        src.j     = p2_q.j;
        src.m     = p2_q.m;
        src.c     = p2_q.c;
        src.crem  = '0;
        src.num   = p2_q.num;
        src.rem   = '0;
        src.quo   = '0;
        src.prod  = p2_q.prod;
      end
    end else begin : g_next
      assign src_vld = d1_vld_q[k-1];
      assign src     = d1_q[k-1];
    end

    if (k < WordW) begin : g_crem
      logic [WordW:0]   cr2;
      logic [WordW-1:0] qsel;
      always_comb begin
        qsel = sel_mod(src.j);
        cr2  = {src.crem, src.c[WordW-1-k]};
        if (cr2 >= {1'b0, qsel}) crem_d = WordW'(cr2 - {1'b0, qsel});
        else crem_d = cr2[WordW-1:0];
      end
    end else begin : g_crem_hold
      assign crem_d = src.crem;
    end

    always_comb begin
      nxt      = src;
      nxt.crem = crem_d;
      r2       = {src.rem, src.num[NumW-1-k]};
      if (r2 >= {1'b0, plain_mod_q}) begin
        nxt.rem = WordW'(r2 - {1'b0, plain_mod_q});
        nxt.quo = {src.quo[QuoW-2:0], 1'b1};
      end else begin
        nxt.rem = r2[WordW-1:0];
        nxt.quo = {src.quo[QuoW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) d1_vld_q[k] <= 1'b0;
      else if (en) d1_vld_q[k] <= src_vld;
    end

    always_ff @(posedge clk_i) begin
      if (en) d1_q[k] <= nxt;
    end
  end

  // merge: build dividend of the term
  logic p3_vld_q;
  d2_t  p3_q, p3_d;
  logic [QuoW-1:0] fix;
  always_comb begin
    fix       = (plain_mod_q == '0) ? '0 : d1_q[NumW-1].quo;
    p3_d.op   = d1_q[NumW-1].op;
    p3_d.j    = d1_q[NumW-1].j;
    p3_d.c    = d1_q[NumW-1].c;
    p3_d.crem = d1_q[NumW-1].crem;
    p3_d.rem  = '0;
    if (d1_q[NumW-1].op == OP_ADD_SCALED || d1_q[NumW-1].op == OP_SUB_SCALED) begin
      p3_d.num = NumW'(d1_q[NumW-1].prod) + NumW'(fix);
    end else begin
      p3_d.num = NumW'(d1_q[NumW-1].m);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p3_vld_q <= 1'b0;
    else if (en) p3_vld_q <= d1_vld_q[NumW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) p3_q <= p3_d;
  end

  // divider 2: term = dividend mod q_j
  logic d2_vld_q [NumW];
  d2_t  d2_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_div2
    d2_t              src, nxt;
    logic             src_vld;
    logic [WordW:0]   r2;
    logic [WordW-1:0] qsel;
    if (k == 0) begin : g_first
      assign src_vld = p3_vld_q;
      assign src     = p3_q;
    end else begin : g_next
      assign src_vld = d2_vld_q[k-1];
      assign src     = d2_q[k-1];
    end

    always_comb begin
      nxt  = src;
      qsel = sel_mod(src.j);
      r2   = {src.rem, src.num[NumW-1-k]};
      if (r2 >= {1'b0, qsel}) nxt.rem = WordW'(r2 - {1'b0, qsel});
      else nxt.rem = r2[WordW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) d2_vld_q[k] <= 1'b0;
      else if (en) d2_vld_q[k] <= src_vld;
    end

    always_ff @(posedge clk_i) begin
      if (en) d2_q[k] <= nxt;
    end
  end

  // final add or subtract
  d2_t              fin;
  logic [WordW-1:0] fq, res;
  logic [WordW:0]   fsum;
  always_comb begin
    fin  = d2_q[NumW-1];
    fq   = sel_mod(fin.j);
    fsum = '0;
    if ({1'b0, fin.j} >= 3'(NUM_MODULI)) begin
      res = fin.c;
    end else if (fq == '0) begin
      res = '0;
    end else if (fin.op == OP_ADD || fin.op == OP_ADD_SCALED) begin
      fsum = {1'b0, fin.crem} + {1'b0, fin.rem};
      if (fsum >= {1'b0, fq}) fsum = fsum - {1'b0, fq};
      res = fsum[WordW-1:0];
    end else begin
      if (fin.crem >= fin.rem) begin
        res = fin.crem - fin.rem;
      end else begin
        fsum = {1'b0, fin.crem} + {1'b0, fq} - {1'b0, fin.rem};
        res  = fsum[WordW-1:0];
      end
    end
  end

  // output register and skid
  logic new_vld, out_free;
  assign new_vld  = en && d2_vld_q[NumW-1];
  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_free) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (new_vld) begin
      if (out_free) out_vld_q <= 1'b1;
      else skid_vld_q <= 1'b1;
    end else if (out_free) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_free) out_q <= skid_q;
    end else if (new_vld) begin
      if (out_free) out_q <= res;
      else skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataW'(out_q);

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a word while output is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
    else $error("skid filled without an output stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> out_vld_q && $stable(out_q))
    else $error("stalled output word lost");

endmodule
